// ===== src/gbcm_pkg.sv =====
// GOST 28147-89 cipher with key meshing: shared types, constants and functions.
// S-box sets, meshing constant, register indexes, state encoding, round helpers.
// Standalone package, used by gbcm_round and gost_block_cipher_meshing.
package gbcm_pkg;

    localparam int MESH_INTERVAL_DEF = 128;
    localparam int ROUNDS            = 32;
    localparam int ROUND_W           = $clog2(ROUNDS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DATA,
        ST_FIN,
        ST_MESH,
        ST_IVMESH
    } state_t;

    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t REG_KEY01   = 3'd0;
    localparam cfg_idx_t REG_KEY23   = 3'd1;
    localparam cfg_idx_t REG_KEY45   = 3'd2;
    localparam cfg_idx_t REG_KEY67   = 3'd3;
    localparam cfg_idx_t REG_IV      = 3'd4;
    localparam cfg_idx_t REG_SBOX    = 3'd5;
    localparam cfg_idx_t REG_CHAIN   = 3'd6;
    localparam cfg_idx_t REG_DECRYPT = 3'd7;

    localparam logic [1:0] SBOX_TEST   = 2'd0;
    localparam logic [1:0] SBOX_CPA    = 2'd1;
    localparam logic [1:0] SBOX_Z      = 2'd2;
    localparam logic [1:0] SBOX_UNUSED = 2'd3;

    localparam logic [1:0] MESH_LAST = 2'd3;

    localparam logic [3:0] SBOX [3][8][16] = '{
        '{
            '{4'h4, 4'h2, 4'hF, 4'h5, 4'h9, 4'h1, 4'h0, 4'h8,
              4'hE, 4'h3, 4'hB, 4'hC, 4'hD, 4'h7, 4'hA, 4'h6},
            '{4'hC, 4'h9, 4'hF, 4'hE, 4'h8, 4'h1, 4'h3, 4'hA,
              4'h2, 4'h7, 4'h4, 4'hD, 4'h6, 4'h0, 4'hB, 4'h5},
            '{4'hD, 4'h8, 4'hE, 4'hC, 4'h7, 4'h3, 4'h9, 4'hA,
              4'h1, 4'h5, 4'h2, 4'h4, 4'h6, 4'hF, 4'h0, 4'hB},
            '{4'hE, 4'h9, 4'hB, 4'h2, 4'h5, 4'hF, 4'h7, 4'h1,
              4'h0, 4'hD, 4'hC, 4'h6, 4'hA, 4'h4, 4'h3, 4'h8},
            '{4'h3, 4'hE, 4'h5, 4'h9, 4'h6, 4'h8, 4'h0, 4'hD,
              4'hA, 4'hB, 4'h7, 4'hC, 4'h2, 4'h1, 4'hF, 4'h4},
            '{4'h8, 4'hF, 4'h6, 4'hB, 4'h1, 4'h9, 4'hC, 4'h5,
              4'hD, 4'h3, 4'h7, 4'hA, 4'h0, 4'hE, 4'h2, 4'h4},
            '{4'h9, 4'hB, 4'hC, 4'h0, 4'h3, 4'h6, 4'h7, 4'h5,
              4'h4, 4'h8, 4'hE, 4'hF, 4'h1, 4'hA, 4'h2, 4'hD},
            '{4'hC, 4'h6, 4'h5, 4'h2, 4'hB, 4'h0, 4'h9, 4'hD,
              4'h3, 4'hE, 4'h7, 4'hA, 4'hF, 4'h4, 4'h1, 4'h8}
        },
        '{
            '{4'h9, 4'h6, 4'h3, 4'h2, 4'h8, 4'hB, 4'h1, 4'h7,
              4'hA, 4'h4, 4'hE, 4'hF, 4'hC, 4'h0, 4'hD, 4'h5},
            '{4'h3, 4'h7, 4'hE, 4'h9, 4'h8, 4'hA, 4'hF, 4'h0,
              4'h5, 4'h2, 4'h6, 4'hC, 4'hB, 4'h4, 4'hD, 4'h1},
            '{4'hE, 4'h4, 4'h6, 4'h2, 4'hB, 4'h3, 4'hD, 4'h8,
              4'hC, 4'hF, 4'h5, 4'hA, 4'h0, 4'h7, 4'h1, 4'h9},
            '{4'hE, 4'h7, 4'hA, 4'hC, 4'hD, 4'h1, 4'h3, 4'h9,
              4'h0, 4'h2, 4'hB, 4'h4, 4'hF, 4'h8, 4'h5, 4'h6},
            '{4'hB, 4'h5, 4'h1, 4'h9, 4'h8, 4'hD, 4'hF, 4'h0,
              4'hE, 4'h4, 4'h2, 4'h3, 4'hC, 4'h7, 4'hA, 4'h6},
            '{4'h3, 4'hA, 4'hD, 4'hC, 4'h1, 4'h2, 4'h0, 4'hB,
              4'h7, 4'h5, 4'h9, 4'h4, 4'h8, 4'hF, 4'hE, 4'h6},
            '{4'h1, 4'hD, 4'h2, 4'h9, 4'h7, 4'hA, 4'h6, 4'h0,
              4'h8, 4'hC, 4'h4, 4'h5, 4'hF, 4'h3, 4'hB, 4'hE},
            '{4'hB, 4'hA, 4'hF, 4'h5, 4'h0, 4'hC, 4'hE, 4'h8,
              4'h6, 4'h2, 4'h3, 4'h9, 4'h1, 4'h7, 4'hD, 4'h4}
        },
        '{
            '{4'hC, 4'h4, 4'h6, 4'h2, 4'hA, 4'h5, 4'hB, 4'h9,
              4'hE, 4'h8, 4'hD, 4'h7, 4'h0, 4'h3, 4'hF, 4'h1},
            '{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'hA, 4'h5, 4'hC,
              4'h1, 4'hE, 4'h4, 4'h7, 4'hB, 4'hD, 4'h0, 4'hF},
            '{4'hB, 4'h3, 4'h5, 4'h8, 4'h2, 4'hF, 4'hA, 4'hD,
              4'hE, 4'h1, 4'h7, 4'h4, 4'hC, 4'h9, 4'h6, 4'h0},
            '{4'hC, 4'h8, 4'h2, 4'h1, 4'hD, 4'h4, 4'hF, 4'h6,
              4'h7, 4'h0, 4'hA, 4'h5, 4'h3, 4'hE, 4'h9, 4'hB},
            '{4'h7, 4'hF, 4'h5, 4'hA, 4'h8, 4'h1, 4'h6, 4'hD,
              4'h0, 4'h9, 4'h3, 4'hE, 4'hB, 4'h4, 4'h2, 4'hC},
            '{4'h5, 4'hD, 4'hF, 4'h6, 4'h9, 4'h2, 4'hC, 4'hA,
              4'hB, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'hE, 4'h0},
            '{4'h8, 4'hE, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hC,
              4'hF, 4'h4, 4'hB, 4'h0, 4'hD, 4'hA, 4'h3, 4'h7},
            '{4'h1, 4'h7, 4'hE, 4'hD, 4'h0, 4'h5, 4'h8, 4'h3,
              4'h4, 4'hF, 4'hA, 4'h6, 4'h9, 4'hC, 4'hB, 4'h2}
        }
    };

    localparam logic [63:0] MESH_CONST [4] = '{
        64'h2304C96422720069, 64'hC42AE94696DB3A8D,
        64'h1207ED0094ACFE18, 64'h2BA94CEFC2DC86C0
    };

    // unused selector falls back to CryptoPro A
    function automatic logic [1:0] table_sel(logic [1:0] sel);
        logic [1:0] t;
        unique case (sel)
            SBOX_TEST:   t = SBOX_TEST;
            SBOX_CPA:    t = SBOX_CPA;
            SBOX_Z:      t = SBOX_Z;
            SBOX_UNUSED: t = SBOX_CPA;
        endcase
        return t;
    endfunction

    // enc: 0..7 x3 then 7..0; dec: 0..7 then 7..0 x3
    function automatic logic [2:0] key_index(logic [ROUND_W-1:0] rnd, logic dec);
        logic [2:0] idx;
        if (dec) begin
            idx = (rnd[4:3] == 2'b00) ? rnd[2:0] : ~rnd[2:0];
        end else begin
            idx = (rnd[4:3] == 2'b11) ? ~rnd[2:0] : rnd[2:0];
        end
        return idx;
    endfunction

    function automatic logic [31:0] sbox_sub(logic [1:0] tab, logic [31:0] s);
        logic [31:0] t;
        t = '0;
        for (int i = 0; i < 8; i++) begin
            t[4*i +: 4] = SBOX[tab][i][s[4*i +: 4]];
        end
        return t;
    endfunction

endpackage

// ===== src/gost_block_cipher_meshing.sv =====
// Top level: GOST 28147-89 ECB/CBC cipher with CryptoPro key meshing.
// Sequencer, key/chaining state, config registers and output register.
// Depends on gbcm_pkg and gbcm_round.
//
//   channel | ports                                      | direction
//   s_      | s_valid s_ready s_block_in s_start_stream  | in, valid/ready
//           | s_last_block                               |
//   m_      | m_valid m_ready m_block_out m_last_out     | out, valid/ready
//   cfg_    | cfg_we cfg_index cfg_wdata                 | in, write only
//
// A block runs its rounds on the shared round unit from transfer to result,
// and the finish state then loads the output register.
// Every MESH_INTERVAL_BLOCKS-th block adds a key meshing pass over the
// meshing constants, and in CBC an IV meshing pass; s_ready stays low meanwhile.
// The output register lets a new block start while a result waits; the
// finish cycle stalls until the output register is free.
// Reset (synchronous, active low) clears key, chaining value and counter.
module gost_block_cipher_meshing #(
    parameter int MESH_INTERVAL_BLOCKS = gbcm_pkg::MESH_INTERVAL_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [63:0]        s_block_in,
    input  logic               s_start_stream,
    input  logic               s_last_block,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [63:0]        m_block_out,
    output logic               m_last_out,
    input  logic               cfg_we,
    input  gbcm_pkg::cfg_idx_t cfg_index,
    input  logic [63:0]        cfg_wdata
);
    import gbcm_pkg::*;

    localparam int CNT_W = $clog2(MESH_INTERVAL_BLOCKS);
    localparam logic [CNT_W:0] MESH_CNT = MESH_INTERVAL_BLOCKS[CNT_W:0];
    localparam logic [ROUND_W-1:0] LAST_RND = ROUND_W'(ROUNDS - 1);

    // config registers
    logic [63:0] cfg_key_reg [4];
    logic [63:0] iv_start_reg;
    logic [1:0]  sbox_set_reg;
    logic        chain_mode_reg;
    logic        decrypt_mode_reg;

    // control and cipher state
    state_t             state_reg, state_next;
    logic [ROUND_W-1:0] round_reg;
    logic [1:0]         mesh_idx_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [31:0]        key_reg [8];
    logic [31:0]        mesh_key_reg [8];
    logic [63:0]        cv_reg;
    logic [31:0]        n1_reg, n2_reg;
    logic [63:0]        blk_reg;
    logic               last_reg;
    logic               out_valid_reg;
    logic [63:0]        out_block_reg;
    logic               out_last_reg;

    logic               rnd_dec;
    logic               last_round;
    logic               out_free;
    logic               mesh_due;
    logic [CNT_W:0]     cnt_inc;
    logic [63:0]        cv_sel;
    logic [63:0]        data_in;
    logic [63:0]        res;
    logic [31:0]        rn1, rn2;
    logic [63:0]        next_const;

    gbcm_round u_round (
        .n1_i  (n1_reg),
        .n2_i  (n2_reg),
        .key_i (key_reg[key_index(round_reg, rnd_dec)]),
        .tab_i (table_sel(sbox_set_reg)),
        .n1_o  (rn1),
        .n2_o  (rn2)
    );

    assign last_round = (round_reg == LAST_RND);
    assign out_free   = !out_valid_reg || m_ready;
    assign cnt_inc    = {1'b0, cnt_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign mesh_due   = (cnt_inc == MESH_CNT);
    assign cv_sel     = s_start_stream ? iv_start_reg : cv_reg;
    assign data_in    = (chain_mode_reg && !decrypt_mode_reg) ? (s_block_in ^ cv_sel)
                                                              : s_block_in;
    assign res        = (chain_mode_reg && decrypt_mode_reg) ? ({n1_reg, n2_reg} ^ cv_reg)
                                                             : {n1_reg, n2_reg};
    assign next_const = MESH_CONST[mesh_idx_reg + 2'd1];

    assign m_valid     = out_valid_reg;
    assign m_block_out = out_block_reg;
    assign m_last_out  = out_last_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_DATA;
            ST_DATA:   if (last_round) state_next = ST_FIN;
            ST_FIN:    if (out_free) state_next = mesh_due ? ST_MESH : ST_IDLE;
            ST_MESH: begin
                if (last_round && mesh_idx_reg == MESH_LAST) begin
                    state_next = chain_mode_reg ? ST_IVMESH : ST_IDLE;
                end
            end
            ST_IVMESH: if (last_round) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        rnd_dec = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready = 1'b1;
            ST_DATA:   rnd_dec = decrypt_mode_reg;
            ST_FIN:    rnd_dec = 1'b0;
            ST_MESH:   rnd_dec = 1'b1;
            ST_IVMESH: rnd_dec = 1'b0;
            default:   rnd_dec = 1'b0;
        endcase
    end

    // control state, keys, chaining value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            round_reg        <= '0;
            mesh_idx_reg     <= '0;
            cnt_reg          <= '0;
            cv_reg           <= '0;
            out_valid_reg    <= 1'b0;
            iv_start_reg     <= '0;
            sbox_set_reg     <= SBOX_CPA;
            chain_mode_reg   <= 1'b0;
            decrypt_mode_reg <= 1'b0;
            for (int i = 0; i < 4; i++) cfg_key_reg[i] <= '0;
            for (int i = 0; i < 8; i++) key_reg[i] <= '0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_index)
                    REG_KEY01:   cfg_key_reg[0]   <= cfg_wdata;
                    REG_KEY23:   cfg_key_reg[1]   <= cfg_wdata;
                    REG_KEY45:   cfg_key_reg[2]   <= cfg_wdata;
                    REG_KEY67:   cfg_key_reg[3]   <= cfg_wdata;
                    REG_IV:      iv_start_reg     <= cfg_wdata;
                    REG_SBOX:    sbox_set_reg     <= cfg_wdata[1:0];
                    REG_CHAIN:   chain_mode_reg   <= cfg_wdata[0];
                    REG_DECRYPT: decrypt_mode_reg <= cfg_wdata[0];
                endcase
            end

            if (state_reg == ST_FIN && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    round_reg <= '0;
                    if (s_valid && s_start_stream) begin
                        for (int i = 0; i < 4; i++) begin
                            key_reg[2*i]   <= cfg_key_reg[i][31:0];
                            key_reg[2*i+1] <= cfg_key_reg[i][63:32];
                        end
                        cv_reg  <= iv_start_reg;
                        cnt_reg <= '0;
                    end
                end
                ST_DATA: round_reg <= round_reg + 1'b1;
                ST_FIN: begin
                    round_reg    <= '0;
                    mesh_idx_reg <= '0;
                    if (out_free) begin
                        if (chain_mode_reg) begin
                            cv_reg <= decrypt_mode_reg ? blk_reg : res;
                        end
                        cnt_reg <= mesh_due ? '0 : cnt_inc[CNT_W-1:0];
                    end
                end
                ST_MESH: begin
                    round_reg <= round_reg + 1'b1;
                    if (last_round) begin
                        mesh_idx_reg <= mesh_idx_reg + 2'd1;
                        if (mesh_idx_reg == MESH_LAST) begin
                            for (int i = 0; i < 6; i++) key_reg[i] <= mesh_key_reg[i];
                            key_reg[6] <= rn2;
                            key_reg[7] <= rn1;
                        end
                    end
                end
                ST_IVMESH: begin
                    round_reg <= round_reg + 1'b1;
                    if (last_round) cv_reg <= {rn1, rn2};
                end
                default: round_reg <= '0;
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    n1_reg   <= data_in[31:0];
                    n2_reg   <= data_in[63:32];
                    blk_reg  <= s_block_in;
                    last_reg <= s_last_block;
                end
            end
            ST_DATA: begin
                n1_reg <= rn1;
                n2_reg <= rn2;
            end
            ST_FIN: begin
                if (out_free) begin
                    out_block_reg <= res;
                    out_last_reg  <= last_reg;
                    n1_reg        <= MESH_CONST[0][31:0];
                    n2_reg        <= MESH_CONST[0][63:32];
                end
            end
            ST_MESH: begin
                if (last_round) begin
                    mesh_key_reg[{mesh_idx_reg, 1'b0}] <= rn2;
                    mesh_key_reg[{mesh_idx_reg, 1'b1}] <= rn1;
                    if (mesh_idx_reg == MESH_LAST) begin
                        n1_reg <= cv_reg[31:0];
                        n2_reg <= cv_reg[63:32];
                    end else begin
                        n1_reg <= next_const[31:0];
                        n2_reg <= next_const[63:32];
                    end
                end else begin
                    n1_reg <= rn1;
                    n2_reg <= rn2;
                end
            end
            ST_IVMESH: begin
                n1_reg <= rn1;
                n2_reg <= rn2;
            end
            default: begin
                n1_reg <= n1_reg;
            end
        endcase
    end

    a_data_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DATA && last_round) |=> (state_reg == ST_FIN))
        else $error("data pass did not end in finish cycle");

    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready high right after input transfer");

    a_mesh_cnt_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MESH) |-> (cnt_reg == '0))
        else $error("block counter not cleared during meshing");

    a_fin_writes_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && out_free) |=> m_valid)
        else $error("finish cycle did not load output register");

endmodule

// ===== src/gbcm_round.sv =====
// One GOST 28147-89 Feistel round: key add, S-box layer, rotate by 11, xor.
// Shared by data, key meshing and IV meshing passes.
// Depends on gbcm_pkg.
module gbcm_round (
    input  logic [31:0] n1_i,
    input  logic [31:0] n2_i,
    input  logic [31:0] key_i,
    input  logic [1:0]  tab_i,
    output logic [31:0] n1_o,
    output logic [31:0] n2_o
);
    import gbcm_pkg::*;

    logic [31:0] sum;
    logic [31:0] sub;

    assign sum  = n1_i + key_i;
    assign sub  = sbox_sub(tab_i, sum);
    assign n1_o = {sub[20:0], sub[31:21]} ^ n2_i;
    assign n2_o = n1_i;

endmodule
